/* hdl/rcwc_pkg.sv */
`default_nettype none
package rcwc_pkg;

    localparam int TEX_DIM         = 64;
    localparam int GRID_UNIT       = 64;
    localparam int MAX_ROWS        = 1024;
    localparam int COS_TABLE_DEPTH = 1024;

    localparam int TEX_BITS  = $clog2(TEX_DIM);
    localparam int TEX_DEPTH = 4 * TEX_DIM * TEX_DIM;
    localparam int TADDR_W   = 14;

    localparam int HEIGHT_W = 20;
    localparam int STEP_W   = 24;

    // Divider numerator width: enough for both the height and the step quotient
    localparam int NUM_H_W = $clog2(GRID_UNIT * 16) + 16;
    localparam int NUM_S_W = TEX_BITS + 17;
    localparam int DIV_NW  = (NUM_H_W > NUM_S_W) ? NUM_H_W : NUM_S_W;
    localparam int DIV_DW  = HEIGHT_W;
    localparam int DIV_CW  = $clog2(DIV_NW);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int S_TDATA_W = 128;

    typedef enum logic [1:0] {
        FUNC_TEXEL  = 2'd0,
        FUNC_COLUMN = 2'd1,
        FUNC_ROW    = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REGION_CEIL  = 2'd0,
        REGION_WALL  = 2'd1,
        REGION_FLOOR = 2'd2,
        REGION_NONE  = 2'd3
    } region_t;

    typedef enum logic [1:0] {
        CFG_PROJ_SCALE = 2'd0,
        CFG_SCREEN_H   = 2'd1,
        CFG_CEIL_COLOR = 2'd2,
        CFG_FLOOR_COLOR = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] projection_scale;
        logic [10:0] screen_height;
        logic [23:0] ceiling_color;
        logic [23:0] floor_color;
    } cfg_t;

    typedef struct packed {
        func_t       func;
        logic [13:0] texel_address;
        logic [23:0] texel_color;
        logic [19:0] ray_distance;
        logic [11:0] ray_angle;
        logic [11:0] player_angle;
        logic        hit_vertical;
        logic        facing_left;
        logic        facing_up;
        logic [15:0] hit_x;
        logic [15:0] hit_y;
        logic [9:0]  row;
    } item_t;

endpackage
`default_nettype wire

/* hdl/rcwc_front.sv */
`default_nettype none
module rcwc_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // texel_address, texel_color, ray_distance, ray_angle, player_angle,
    // hit_vertical, facing_left, facing_up, hit_x, hit_y, row, zero pad
    input  wire logic [rcwc_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [1:0]                    s_tuser,
    output logic                               q_valid,
    output rcwc_pkg::item_t                    q_item,
    input  wire logic                          q_pop
);
    import rcwc_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    item_t             decoded;
    logic              push;
    logic              pop;

    // Unpack the request into its fields
    always_comb begin
        decoded.func          = func_t'(s_tuser);
        decoded.texel_address = s_tdata[13:0];
        decoded.texel_color   = s_tdata[37:14];
        decoded.ray_distance  = s_tdata[57:38];
        decoded.ray_angle     = s_tdata[69:58];
        decoded.player_angle  = s_tdata[81:70];
        decoded.hit_vertical  = s_tdata[82];
        decoded.facing_left   = s_tdata[83];
        decoded.facing_up     = s_tdata[84];
        decoded.hit_x         = s_tdata[100:85];
        decoded.hit_y         = s_tdata[116:101];
        decoded.row           = s_tdata[126:117];
    end

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    // Drop unused selector codes, queue the rest
    always_comb begin
        case (decoded.func)
            FUNC_TEXEL, FUNC_COLUMN, FUNC_ROW: push = s_tvalid && s_tready;
            default:                           push = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/rcwc_div.sv */
`default_nettype none
module rcwc_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [rcwc_pkg::DIV_NW-1:0] numer,
    input  wire logic [rcwc_pkg::DIV_DW-1:0] denom,
    output logic                             done,
    output logic [rcwc_pkg::DIV_NW-1:0]      quot
);
    import rcwc_pkg::*;

    logic [DIV_NW-1:0] shift_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    // One restoring step: bring down the next numerator bit
    assign trial = {rem_reg, shift_reg[DIV_NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quot  = shift_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= numer;
            den_reg   <= denom;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[DIV_NW-2:0], fits};
            rem_reg   <= fits ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DIV_NW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/rcwc_back.sv */
`default_nettype none
module rcwc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire rcwc_pkg::item_t q_item,
    output logic                 q_pop,
    input  wire rcwc_pkg::cfg_t  cfg,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [23:0]          m_tdata,
    output logic [1:0]           m_tuser
);
    import rcwc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_COS_W   = 13'b0000000000010,
        S_COS_T1  = 13'b0000000000100,
        S_COS_T2  = 13'b0000000001000,
        S_COS_T3  = 13'b0000000010000,
        S_COS_T4  = 13'b0000000100000,
        S_PERP    = 13'b0000001000000,
        S_DIV_H   = 13'b0000010000000,
        S_HGT     = 13'b0000100000000,
        S_DIV_S   = 13'b0001000000000,
        S_ROW_MUL = 13'b0010000000000,
        S_ROW_RD  = 13'b0100000000000,
        S_ROW_OUT = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] tex_mem [TEX_DEPTH];
    logic [23:0] rdata_reg;
    logic [TADDR_W-1:0] raddr;

    // Column state
    logic [10:0]         top_reg, bottom_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [TEX_BITS-1:0] tex_col_reg;
    logic [1:0]          tex_num_reg;
    logic [STEP_W-1:0]   step_reg;

    // Working registers
    logic [19:0]         dist_reg;
    logic [16:0]         u_reg, w_reg, t_reg, cos_reg;
    logic [9:0]          row_reg;
    region_t             region_reg;
    logic [TEX_BITS-1:0] ty_reg;

    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    region_t     m_region_reg;

    // Shared multiplier
    logic [23:0] mul_a, mul_b;
    logic [47:0] mul_p;

    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_done;
    logic [DIV_NW-1:0] div_quot;

    logic [11:0]       ang_diff;
    logic [10:0]       ang_fold;
    logic [31:0]       cos_idx;
    logic [31:0]       cos_u;
    logic [TEX_BITS-1:0] col_raw;
    logic [10:0]       eff;
    logic [9:0]        half;
    logic [18:0]       hh;
    logic [19:0]       half_sum;
    logic [20:0]       off_s;
    logic [19:0]       off;
    logic [19:0]       perp;
    logic              out_free;
    logic              idle_pop;

    rcwc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign mul_p = mul_a * mul_b;

    // Rows in use, half height and half wall height
    assign eff      = (cfg.screen_height > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : cfg.screen_height;
    assign half     = eff[10:1];
    assign hh       = height_reg[HEIGHT_W-1:1];
    assign half_sum = {10'b0, half} + {1'b0, hh};
    assign off_s    = {11'b0, row_reg} + {2'b0, hh} - {11'b0, half};
    assign off      = off_s[20] ? '0 : off_s[19:0];
    assign perp     = mul_p[35:16];

    // Fold the view angle to a quarter turn for the cosine index
    assign ang_diff = q_item.ray_angle - q_item.player_angle;
    assign ang_fold = (ang_diff[10:0] > 11'd1024) ? 11'(12'd2048 - {1'b0, ang_diff[10:0]})
                                                   : ang_diff[10:0];
    assign cos_idx  = ({21'b0, ang_fold} * 32'(COS_TABLE_DEPTH)) >> 10;
    assign cos_u    = (cos_idx << 16) / COS_TABLE_DEPTH;

    assign col_raw = q_item.hit_vertical ? q_item.hit_y[TEX_BITS-1:0]
                                         : q_item.hit_x[TEX_BITS-1:0];

    assign raddr    = TADDR_W'((({30'b0, tex_num_reg} * 32'(TEX_DIM) + 32'(ty_reg))
                               * 32'(TEX_DIM)) + 32'(tex_col_reg));
    assign out_free = !m_valid_reg || m_tready;
    assign idle_pop = (state_reg == S_IDLE) && q_valid;
    assign q_pop    = idle_pop;

    // Pick multiplier operands and divider operands per step
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_COS_W: begin
                mul_a = {7'b0, u_reg};
                mul_b = {7'b0, u_reg};
            end
            S_COS_T1: begin
                mul_a = {7'b0, w_reg};
                mul_b = 24'd60;
            end
            S_COS_T2, S_COS_T3, S_COS_T4: begin
                mul_a = {7'b0, w_reg};
                mul_b = {7'b0, t_reg};
            end
            S_PERP: begin
                mul_a     = {4'b0, dist_reg};
                mul_b     = {7'b0, cos_reg};
                div_start = (perp != '0);
                div_num   = DIV_NW'(32'(GRID_UNIT * 16) * {16'b0, cfg.projection_scale});
                div_den   = perp;
            end
            S_HGT: begin
                div_start = (height_reg != '0);
                div_num   = DIV_NW'(32'(TEX_DIM) << 16);
                div_den   = height_reg;
            end
            S_ROW_MUL: begin
                mul_a = {4'b0, off};
                mul_b = step_reg;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Sequence the back end
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    case (q_item.func)
                        FUNC_COLUMN: state_next = S_COS_W;
                        FUNC_ROW:    state_next = S_ROW_MUL;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_COS_W:   state_next = S_COS_T1;
            S_COS_T1:  state_next = S_COS_T2;
            S_COS_T2:  state_next = S_COS_T3;
            S_COS_T3:  state_next = S_COS_T4;
            S_COS_T4:  state_next = S_PERP;
            S_PERP:    state_next = (perp != '0) ? S_DIV_H : S_HGT;
            S_DIV_H:   state_next = div_done ? S_HGT : S_DIV_H;
            S_HGT:     state_next = (height_reg != '0) ? S_DIV_S : S_IDLE;
            S_DIV_S:   state_next = div_done ? S_IDLE : S_DIV_S;
            S_ROW_MUL: state_next = S_ROW_RD;
            S_ROW_RD:  state_next = S_ROW_OUT;
            S_ROW_OUT: state_next = out_free ? S_IDLE : S_ROW_OUT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Texture store: write on texel requests, registered read
    always_ff @(posedge aclk) begin
        if (idle_pop && (q_item.func == FUNC_TEXEL) &&
            ({18'b0, q_item.texel_address} < 32'(TEX_DEPTH))) begin
            tex_mem[q_item.texel_address] <= q_item.texel_color;
        end
        rdata_reg <= tex_mem[raddr];
    end

    // Working registers of the column and row steps
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                dist_reg <= q_item.ray_distance;
                u_reg    <= cos_u[16:0];
                row_reg  <= q_item.row;
            end
            S_COS_W:  w_reg <= mul_p[32:16];
            S_COS_T1: t_reg <= 17'(17'd1367 - mul_p[32:16]);
            S_COS_T2: t_reg <= 17'(17'd16624 - mul_p[32:16]);
            S_COS_T3: t_reg <= 17'(17'd80852 - mul_p[32:16]);
            S_COS_T4: cos_reg <= (mul_p[32:16] >= 17'd65536) ? 17'd0
                                                              : 17'(17'd65536 - mul_p[32:16]);
            S_ROW_MUL: begin
                if ({1'b0, row_reg} < top_reg) begin
                    region_reg <= REGION_CEIL;
                end else if ({1'b0, row_reg} < bottom_reg) begin
                    region_reg <= REGION_WALL;
                end else begin
                    region_reg <= REGION_FLOOR;
                end
                ty_reg <= (|mul_p[47:16+TEX_BITS]) ? TEX_BITS'(TEX_DIM - 1)
                                                   : mul_p[16+TEX_BITS-1:16];
            end
            default: begin
                t_reg <= t_reg;
            end
        endcase
    end

    // Column state updated as the load proceeds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            bottom_reg  <= '0;
            height_reg  <= '0;
            tex_col_reg <= '0;
            tex_num_reg <= '0;
            step_reg    <= '0;
        end else begin
            if (idle_pop && (q_item.func == FUNC_COLUMN)) begin
                if (q_item.hit_vertical) begin
                    tex_col_reg <= q_item.facing_left ? ~col_raw : col_raw;
                    tex_num_reg <= q_item.facing_left ? 2'd3 : 2'd2;
                end else begin
                    tex_col_reg <= q_item.facing_up ? col_raw : ~col_raw;
                    tex_num_reg <= q_item.facing_up ? 2'd0 : 2'd1;
                end
            end
            if ((state_reg == S_PERP) && (perp == '0)) begin
                height_reg <= '1;
            end
            if ((state_reg == S_DIV_H) && div_done) begin
                height_reg <= (|div_quot[DIV_NW-1:HEIGHT_W]) ? '1 : div_quot[HEIGHT_W-1:0];
            end
            if (state_reg == S_HGT) begin
                top_reg    <= ({1'b0, hh} >= {10'b0, half}) ? '0 : 11'({1'b0, half} - hh);
                bottom_reg <= (half_sum > {9'b0, eff}) ? eff : half_sum[10:0];
                if (height_reg == '0) begin
                    step_reg <= '1;
                end
            end
            if ((state_reg == S_DIV_S) && div_done) begin
                step_reg <= (|div_quot[DIV_NW-1:STEP_W]) ? '1 : div_quot[STEP_W-1:0];
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_ROW_OUT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_ROW_OUT) && out_free) begin
            m_region_reg <= region_reg;
            case (region_reg)
                REGION_CEIL:  m_data_reg <= cfg.ceiling_color;
                REGION_WALL:  m_data_reg <= rdata_reg;
                default:      m_data_reg <= cfg.floor_color;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_region_reg;

endmodule
`default_nettype wire

/* hdl/raycast_wall_column_renderer.sv */
`default_nettype none
// Textured wall column of a grid raycaster. s_tuser selects the request:
// 0 stores a texel, 1 loads a screen column, 2 asks for the colour of one row;
// only row requests give a result (m_tdata colour, m_tuser region 0 ceiling,
// 1 wall, 2 floor). Requests pass a four-entry queue to the back end, which
// works on one at a time: a texel write is stored as it leaves the queue, a row
// request passes the region and texture-row multiply, the registered texture
// read and the output register, and its result may wait on m_tready, a column
// load is paced by the restoring divider that yields one quotient bit a cycle
// and runs twice (wall height, texture step) after six multiplier steps for the
// cosine and distance; a zero distance term or a zero wall height skips a
// division. The texture store has no reset.
module raycast_wall_column_renderer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // texel_address, texel_color, ray_distance, ray_angle, player_angle,
    // hit_vertical, facing_left, facing_up, hit_x, hit_y, row, zero pad
    input  wire logic [rcwc_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // pixel_color
    output logic [23:0]                         m_tdata,
    // region
    output logic [1:0]                          m_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [23:0]                    cfg_wdata
);
    import rcwc_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.projection_scale <= '0;
            cfg_reg.screen_height    <= 11'd480;
            cfg_reg.ceiling_color    <= '0;
            cfg_reg.floor_color      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_PROJ_SCALE: cfg_reg.projection_scale <= cfg_wdata[15:0];
                CFG_SCREEN_H:   cfg_reg.screen_height    <= cfg_wdata[10:0];
                CFG_CEIL_COLOR: cfg_reg.ceiling_color    <= cfg_wdata;
                default:        cfg_reg.floor_color      <= cfg_wdata;
            endcase
        end
    end

    rcwc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rcwc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

/* hdl/rcwc_checker.sv */
`default_nettype none
module rcwc_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [23:0]  m_tdata,
    input wire logic [1:0]   m_tuser
);
    import rcwc_pkg::*;

    // Reset empties the queue and the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("results or queue not cleared by reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only the three region codes appear
    a_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != REGION_NONE)
        else $error("unknown region code");

    // A new result needs reset to have been released earlier, as sampled by $past
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(aresetn, 4))
        else $error("result too soon after reset");

endmodule

bind raycast_wall_column_renderer rcwc_checker u_rcwc_checker (.*);
`default_nettype wire

/* dv/tb_raycast_wall_column_renderer.sv */
`timescale 1ns / 1ps

import rcwc_pkg::*;

typedef struct {
    logic [23:0] color;
    region_t     region;
} pixel_t;

// Tracks the loaded column and texture store, predicts each row colour
class wall_column_predictor;
    logic [23:0] texels [TEX_DEPTH];
    bit          written [TEX_DEPTH];
    logic [15:0] proj_scale;
    logic [10:0] scr_height;
    logic [23:0] ceil_color, floor_color;
    int unsigned top_row, bottom_row, height_px, tex_col, tex_num, row_step;
    pixel_t      expected_pixels[$];
    int          mismatches;

    function new();
        proj_scale = 0; scr_height = 480; ceil_color = 0; floor_color = 0;
        top_row = 0; bottom_row = 0; height_px = 0; tex_col = 0; tex_num = 0;
        row_step = 0; mismatches = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [23:0] val);
        case (idx)
            CFG_PROJ_SCALE:  proj_scale = val[15:0];
            CFG_SCREEN_H:    scr_height = val[10:0];
            CFG_CEIL_COLOR:  ceil_color = val;
            CFG_FLOOR_COLOR: floor_color = val;
            default: ;
        endcase
    endfunction

    function int unsigned rows_used();
        return (scr_height > MAX_ROWS) ? MAX_ROWS : scr_height;
    endfunction

    function longint unsigned cos_q16(int unsigned i);
        longint unsigned u, w, t;
        u = (longint'(i) * 65536) / COS_TABLE_DEPTH;
        w = (u * u) >> 16;
        t = 60;
        t = 1367 - ((w * t) >> 16);
        t = 16624 - ((w * t) >> 16);
        t = 80852 - ((w * t) >> 16);
        t = (w * t) >> 16;
        return (t >= 65536) ? 0 : 65536 - t;
    endfunction

    // Returns 1 when the row lands on the wall, with the texel address
    function bit wall_addr(logic [9:0] row, output logic [13:0] addr);
        longint off, ty;
        addr = 0;
        if (row < top_row || row >= bottom_row) return 0;
        off = longint'(row) + (height_px >> 1) - (rows_used() >> 1);
        if (off < 0) off = 0;
        ty = (off * row_step) >> 16;
        if (ty > TEX_DIM - 1) ty = TEX_DIM - 1;
        addr = 14'(((tex_num * TEX_DIM) + ty) * TEX_DIM + (tex_col % TEX_DIM));
        return 1;
    endfunction

    function void note_request(item_t it);
        longint unsigned perp, h, st;
        int unsigned e, eff, half, hh;
        logic [13:0] a;
        pixel_t px;
        case (it.func)
            FUNC_TEXEL: begin
                texels[it.texel_address] = it.texel_color;
                written[it.texel_address] = 1;
            end
            FUNC_COLUMN: begin
                e = (it.ray_angle - it.player_angle) & 12'hFFF;
                e = e & 2047;
                if (e > 1024) e = 2048 - e;
                perp = (longint'(it.ray_distance) * cos_q16(e * COS_TABLE_DEPTH / 1024)) >> 16;
                if (perp == 0) h = 20'hFFFFF;
                else begin
                    h = (longint'(GRID_UNIT) * proj_scale * 16) / perp;
                    if (h > 20'hFFFFF) h = 20'hFFFFF;
                end
                height_px = h;
                eff = rows_used();
                half = eff >> 1;
                hh = height_px >> 1;
                top_row = (hh >= half) ? 0 : half - hh;
                bottom_row = (half + hh > eff) ? eff : half + hh;
                if (it.hit_vertical) begin
                    tex_col = it.hit_y % TEX_DIM;
                    if (it.facing_left) tex_col = TEX_DIM - 1 - tex_col;
                    tex_num = it.facing_left ? 3 : 2;
                end else begin
                    tex_col = it.hit_x % TEX_DIM;
                    if (!it.facing_up) tex_col = TEX_DIM - 1 - tex_col;
                    tex_num = it.facing_up ? 0 : 1;
                end
                if (height_px == 0) st = 24'hFFFFFF;
                else begin
                    st = (longint'(TEX_DIM) << 16) / height_px;
                    if (st > 24'hFFFFFF) st = 24'hFFFFFF;
                end
                row_step = st;
            end
            FUNC_ROW: begin
                if (it.row < top_row) begin
                    px.color = ceil_color; px.region = REGION_CEIL;
                end else if (wall_addr(it.row, a)) begin
                    px.color = written[a] ? texels[a] : 24'd0;
                    px.region = REGION_WALL;
                end else begin
                    px.color = floor_color; px.region = REGION_FLOOR;
                end
                expected_pixels.push_back(px);
            end
            default: ;
        endcase
    endfunction

    function void check_pixel(logic [23:0] color, logic [1:0] region);
        pixel_t px;
        if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel: colour %h region %0d", color, region);
            return;
        end
        px = expected_pixels.pop_front();
        if (color !== px.color || region !== px.region) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel mismatch: expected %h/%0d, got %h/%0d",
                         px.color, px.region, color, region);
        end
    endfunction
endclass

module tb_raycast_wall_column_renderer;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = 400;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_wdata;

    wall_column_predictor shade = new();
    bit  allow_idle = 1;
    int  sink_hold = 0;
    int  quiet_cycles = 0;

    raycast_wall_column_renderer u_dut (.*);

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Randomly stall the result channel in short bursts
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shade.check_pixel(m_tdata, m_tuser);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(item_t it);
        if (allow_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {1'b0, it.row, it.hit_y, it.hit_x, it.facing_up, it.facing_left,
                     it.hit_vertical, it.player_angle, it.ray_angle, it.ray_distance,
                     it.texel_color, it.texel_address};
        do @(posedge aclk); while (!s_tready);
        shade.note_request(it);
    endtask

    function automatic item_t blank_item(func_t f);
        item_t it;
        it = '0;
        it.func = f;
        it.texel_color = $urandom;
        it.ray_distance = $urandom;
        it.ray_angle = $urandom;
        it.player_angle = $urandom;
        it.hit_x = $urandom;
        it.hit_y = $urandom;
        it.row = $urandom;
        return it;
    endfunction

    task automatic write_texel(logic [13:0] a, logic [23:0] c);
        item_t it;
        it = blank_item(FUNC_TEXEL);
        it.texel_address = a;
        it.texel_color = c;
        send(it);
    endtask

    task automatic load_column(logic [19:0] ray_dist, logic [11:0] ra, logic [11:0] pa,
                               logic [2:0] flags);
        item_t it;
        it = blank_item(FUNC_COLUMN);
        it.ray_distance = ray_dist;
        it.ray_angle = ra;
        it.player_angle = pa;
        {it.hit_vertical, it.facing_left, it.facing_up} = flags;
        send(it);
    endtask

    // Make sure a wall row never reads a texel that was never stored
    task automatic ask_row(logic [9:0] r);
        item_t it;
        logic [13:0] a;
        if (shade.wall_addr(r, a) && !shade.written[a]) write_texel(a, $urandom);
        it = blank_item(FUNC_ROW);
        it.row = r;
        send(it);
    endtask

    // Reprogram only once the block has drained
    task automatic set_view(logic [15:0] ps, logic [10:0] sh, logic [23:0] cc,
                            logic [23:0] fc);
        logic [23:0] vals [4];
        s_tvalid <= 1'b0;
        wait (shade.expected_pixels.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        vals = '{24'(ps), 24'(sh), cc, fc};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            shade.set_reg(cfg_index_t'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int pick;
        item_t it;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                write_texel($urandom, $urandom);
            end else if (pick < 25) begin
                load_column(($urandom_range(0, 9) == 0) ? 20'($urandom)
                                                       : 20'($urandom_range(64, 65535)),
                            $urandom, $urandom, $urandom);
            end else if (pick < 95) begin
                ask_row(($urandom_range(0, 3) == 0) ? 10'($urandom)
                        : 10'($urandom_range(0, shade.rows_used() > 0 ?
                                             shade.rows_used() - 1 : 0)));
            end else begin
                it = blank_item(FUNC_NONE);
                send(it);
                n--;
            end
        end
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= FUNC_TEXEL;
        m_tready <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PROJ_SCALE;
        cfg_wdata <= '0;
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: register reset values, then field extremes and corner cases
        ask_row(10'd0);
        set_view(16'd1000, 11'd480, 24'hFFFFFF, 24'h000000);
        write_texel(14'd0, 24'hFFFFFF);
        write_texel(14'h3FFF, 24'h000000);
        load_column(20'd0, 12'd0, 12'd0, 3'b000);        // zero distance
        ask_row(10'd0);
        ask_row(10'd240);
        ask_row(10'd1023);                               // beyond the screen
        load_column(20'hFFFFF, 12'hFFF, 12'd0, 3'b111);  // tiny wall
        ask_row(10'd240);
        load_column(20'd16384, 12'd1500, 12'd0, 3'b110); // beyond a quarter turn
        ask_row(10'd200);
        ask_row(10'd240);
        load_column(20'd8192, 12'd1024, 12'd0, 3'b101);  // right angle
        ask_row(10'd240);
        load_column(20'd4096, 12'd100, 12'd4000, 3'b001);
        ask_row(10'd100);
        ask_row(10'd400);
        begin
            item_t it;
            it = blank_item(FUNC_NONE);
            send(it);
        end
        // Height changed after the load: current half height applies
        set_view(16'd1000, 11'd100, 24'h123456, 24'h654321);
        ask_row(10'd0);
        ask_row(10'd50);
        ask_row(10'd99);

        set_view(16'd0, 11'd480, $urandom, $urandom);    // zero projection: no wall unless the distance term is zero
        random_phase(150);
        set_view(16'd0, 11'd0, $urandom, $urandom);      // zero screen height
        random_phase(100);
        set_view(16'hFFFF, 11'h7FF, $urandom, $urandom);
        random_phase(250);
        set_view(16'd1, 11'd1, $urandom, $urandom);
        random_phase(150);
        set_view(16'd1000, 11'd480, $urandom, $urandom);
        random_phase(350);
        set_view(16'($urandom_range(200, 8000)), 11'd1024, $urandom, $urandom);
        random_phase(350);
        set_view($urandom, $urandom_range(1, 1024), $urandom, $urandom);
        allow_idle = 0;
        random_phase(350);
        s_tvalid <= 1'b0;

        wait (shade.expected_pixels.size() == 0);
        repeat (SETTLE) @(posedge aclk);
        if (shade.mismatches == 0 && shade.expected_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
